/* design/bdt_pkg.sv */
// ----------------------------------------------------------------------------
// bdt_pkg: shared constants for the beacon de-duplication table
// Operation and status codes, framing constants, default limits and CSR indices.
// ----------------------------------------------------------------------------
package bdt_pkg;
   localparam int TableDepthDefault  = 256;
   localparam int MaxPayloadDefault  = 24;
   localparam logic [1:0] OP_STORE   = 2'd0;
   localparam logic [1:0] OP_POP     = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] ST_ADDED   = 2'd0;
   localparam logic [1:0] ST_UPDATED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_DROPPED = 2'd3;
   localparam logic [11:0] HEADER_BYTES = 12'd7;
   localparam logic [11:0] ENTRY_HDR_BYTES = 12'd2;
   localparam logic [7:0] RSSI_OFFSET = 8'd100;
   localparam logic [10:0] BYTE_LIMIT_RESET = 11'd1024;
   localparam logic [7:0] ENTRY_LIMIT_RESET = 8'd255;
   localparam logic CSR_BYTE_LIMIT = 1'b0;
   localparam logic CSR_ENTRY_LIMIT = 1'b1;
endpackage

/* design/beacon_dedup_table_with_report_drain.sv */
// ----------------------------------------------------------------------------
// beacon_dedup_table_with_report_drain
// Ring table of beacon sightings with de-duplication and a framed drain.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)                   | tuser
// req_    | in  | kind, strength, word_low/mid/high, length      | operation
// rsp_    | out | status, valid, kind, strength+100, words, len, | -
//         |     | msg number, entries, close, report_end         |
// csr_    | in  | index 0 byte limit, 1 entry limit              | -
// A store reads the table one entry a cycle, oldest first, and a hit ends
// the scan early. One item is worked at a time; req_tready is low while an
// item is in flight or its result waits on rsp_tready. Reset is synchronous
// and clears pointers, framing and limits; the memories keep their contents.
// ----------------------------------------------------------------------------
module beacon_dedup_table_with_report_drain
   import bdt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int MAX_PAYLOAD_BYTES = MaxPayloadDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind[7:0], strength[15:8], word_low[79:16], word_mid[143:80],
   // word_high[207:144], length[212:208], zero fill
   input  logic [215:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], valid[2], kind[10:3], strength[18:11], word_low[82:19],
   // word_mid[146:83], word_high[210:147], length[215:211],
   // number[223:216], entries[231:224], close[232], end[233], zero fill
   output logic [239:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [10:0]  csr_wdata
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [4:0] MaxLen = 5'(MAX_PAYLOAD_BYTES);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // table memories
   logic [7:0]   kind_mem [TABLE_DEPTH];
   logic [7:0]   rssi_mem [TABLE_DEPTH];
   logic [4:0]   len_mem  [TABLE_DEPTH];
   logic [191:0] pay_mem  [TABLE_DEPTH];
   logic [7:0]   kind_rd_ff, rssi_rd_ff;
   logic [4:0]   len_rd_ff;
   logic [191:0] pay_rd_ff;

   logic [2:0]   state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in, rd_addr, scan_addr_ff, scan_addr_in;
   logic [CW-1:0] occ_ff, occ_in, scan_cnt_ff, scan_cnt_in;
   logic         open_ff, open_in;
   logic [7:0]   mid_ff, mid_in, ments_ff, ments_in;
   logic [11:0]  mbytes_ff, mbytes_in;
   logic [10:0]  blim_ff;
   logic [7:0]   elim_ff;
   logic [7:0]   kind_ff, rssi_ff;
   logic [4:0]   len_ff;
   logic [191:0] pay_ff, mask_ff;
   logic [239:0] out_ff, out_in;
   logic         we;
   logic [AW-1:0] wa;
   logic [7:0]   w_kind, w_rssi;
   logic [4:0]   w_len;
   logic [191:0] w_pay;
   logic         w_full;
   logic [4:0]   req_len;
   logic [191:0] req_mask;
   logic         hit;
   logic [7:0]   ments_nx;
   logic [11:0]  mbytes_nx;
   logic [AW-1:0] rp_nx;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = out_ff;

   // saturate length and build byte mask
   always_comb begin
      req_len = (req_tdata[212:208] > MaxLen) ? MaxLen : req_tdata[212:208];
      for (int b = 0; b < 24; b++) begin
         req_mask[b*8 +: 8] = (5'(b) < req_len) ? 8'hFF : 8'h00;
      end
   end

   // write and read memories
   always_ff @(posedge clock) begin
      if (we) begin
         kind_mem[wa] <= w_kind;
         rssi_mem[wa] <= w_rssi;
         if (w_full) begin
            len_mem[wa] <= w_len;
            pay_mem[wa] <= w_pay;
         end
      end
      kind_rd_ff <= kind_mem[rd_addr];
      rssi_rd_ff <= rssi_mem[rd_addr];
      len_rd_ff  <= len_mem[rd_addr];
      pay_rd_ff  <= pay_mem[rd_addr];
   end

   assign hit = (kind_rd_ff == kind_ff) && ((pay_rd_ff & mask_ff) == pay_ff);

   always_comb begin
      ments_nx  = ments_ff + 8'd1;
      mbytes_nx = mbytes_ff + 12'(len_rd_ff) + ENTRY_HDR_BYTES;
      rp_nx     = (32'(rp_ff) == TABLE_DEPTH - 1) ? '0 : rp_ff + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff; rp_in = rp_ff; occ_in = occ_ff; open_in = open_ff;
      mid_in = mid_ff; ments_in = ments_ff; mbytes_in = mbytes_ff;
      scan_addr_in = scan_addr_ff; scan_cnt_in = scan_cnt_ff;
      out_in = out_ff;
      rd_addr = scan_addr_ff;
      we = 1'b0; wa = wp_ff; w_full = 1'b1;
      w_kind = kind_ff; w_rssi = rssi_ff; w_len = len_ff; w_pay = pay_ff;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = rp_ff;
            if (req_tvalid) begin
               out_in = '0;
               scan_addr_in = rp_ff;
               scan_cnt_in = '0;
               unique case (req_tuser)
                  OP_STORE: state_in = S_SCAN;
                  OP_POP:   state_in = S_POP;
                  OP_CLEAR: begin
                     wp_in = '0; rp_in = '0; occ_in = '0; open_in = 1'b0;
                     mid_in = 8'd1; ments_in = '0; mbytes_in = HEADER_BYTES;
                     state_in = S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         // issue reads while entries remain
         S_SCAN: begin
            if (scan_cnt_ff == occ_ff) begin
               state_in = S_DONE;
            end else begin
               scan_addr_in = (32'(scan_addr_ff) == TABLE_DEPTH - 1) ? '0
                              : scan_addr_ff + 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
               state_in = S_CMP;
            end
         end
         // compare one entry per cycle, next read in flight
         S_CMP: begin
            if (hit) begin
               out_in[1:0] = ST_UPDATED;
               if ($signed(rssi_rd_ff) < $signed(rssi_ff)) begin
                  we = 1'b1; w_full = 1'b0;
                  wa = scan_addr_ff - 1'b1;
                  if (scan_addr_ff == '0) wa = AW'(TABLE_DEPTH - 1);
                  w_kind = kind_rd_ff;
               end
               state_in = S_OUT;
            end else if (scan_cnt_ff == occ_ff) begin
               state_in = S_DONE;
            end else begin
               scan_addr_in = (32'(scan_addr_ff) == TABLE_DEPTH - 1) ? '0
                              : scan_addr_ff + 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         // append on miss, or drop the sighting when the table is full
         S_DONE: begin
            if (32'(occ_ff) >= TABLE_DEPTH) begin
               out_in[1:0] = ST_DROPPED;
            end else begin
               we = 1'b1;
               wp_in = (32'(wp_ff) == TABLE_DEPTH - 1) ? '0 : wp_ff + 1'b1;
               occ_in = occ_ff + 1'b1;
               out_in[1:0] = (32'(occ_ff) + 1 >= TABLE_DEPTH) ? ST_FULL : ST_ADDED;
            end
            state_in = S_OUT;
         end
         // drain oldest entry and update framing; an empty table closes the report
         S_POP: begin
            state_in = S_OUT;
            if (occ_ff == '0) begin
               out_in[223:216] = 8'd0 - mid_ff;
               out_in[231:224] = ments_ff;
               out_in[233:232] = 2'b11;
               open_in = 1'b0; mid_in = 8'd1; ments_in = '0;
               mbytes_in = HEADER_BYTES;
            end else begin
               logic [7:0]  me;
               logic [11:0] mb;
               logic [7:0]  id;
               me = open_ff ? ments_nx : 8'd1;
               mb = open_ff ? mbytes_nx
                    : HEADER_BYTES + 12'(len_rd_ff) + ENTRY_HDR_BYTES;
               id = open_ff ? mid_ff : 8'd1;
               out_in[2] = 1'b1;
               out_in[10:3] = kind_rd_ff;
               out_in[18:11] = rssi_rd_ff + RSSI_OFFSET;
               out_in[210:19] = pay_rd_ff;
               out_in[215:211] = len_rd_ff;
               out_in[231:224] = me;
               rp_in = rp_nx;
               occ_in = occ_ff - 1'b1;
               open_in = 1'b1; mid_in = id; ments_in = me; mbytes_in = mb;
               if (occ_ff == CW'(1)) begin
                  out_in[223:216] = 8'd0 - id;
                  out_in[233:232] = 2'b11;
                  open_in = 1'b0; mid_in = 8'd1; ments_in = '0;
                  mbytes_in = HEADER_BYTES;
               end else if (mb >= {1'b0, blim_ff} || me >= elim_ff) begin
                  out_in[223:216] = id;
                  out_in[232] = 1'b1;
                  mid_in = id + 8'd1; ments_in = '0; mbytes_in = HEADER_BYTES;
               end else begin
                  out_in[223:216] = id;
               end
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // capture request
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tdata[7:0];
         rssi_ff <= req_tdata[15:8];
         len_ff  <= req_len;
         mask_ff <= req_mask;
         pay_ff  <= req_tdata[207:16] & req_mask;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff <= '0; rp_ff <= '0; occ_ff <= '0; open_ff <= 1'b0;
         mid_ff <= 8'd1; ments_ff <= '0; mbytes_ff <= HEADER_BYTES;
         scan_addr_ff <= '0; scan_cnt_ff <= '0; out_ff <= '0;
         blim_ff <= BYTE_LIMIT_RESET; elim_ff <= ENTRY_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         wp_ff <= wp_in; rp_ff <= rp_in; occ_ff <= occ_in; open_ff <= open_in;
         mid_ff <= mid_in; ments_ff <= ments_in; mbytes_ff <= mbytes_in;
         scan_addr_ff <= scan_addr_in; scan_cnt_ff <= scan_cnt_in;
         out_ff <= out_in;
         if (csr_we) begin
            if (csr_index == CSR_BYTE_LIMIT) blim_ff <= csr_wdata;
            else elim_ff <= csr_wdata[7:0];
         end
      end
   end
endmodule

/* tb/sv/beacon_dedup_table_with_report_drain_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_dedup_table_with_report_drain_tb
// Drives store, pop, clear and unknown operations into the sighting table.
// A scoreboard keeps its own copy of the ring table and the report framing
// state. It predicts every response beat and compares the beats field by
// field. Directed rows come first, then random traffic over several limit
// settings, with a table fill, receiver hold-off and sender pauses.
// ----------------------------------------------------------------------------
module beacon_dedup_table_with_report_drain_tb;
   import bdt_pkg::*;

   localparam int DEPTH = 256;
   localparam int MAXLEN = 24;
   localparam int WATCHDOG_LIMIT = 4000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [215:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [239:0] rsp_tdata;
   logic         csr_we;
   logic         csr_index;
   logic [10:0]  csr_wdata;

   beacon_dedup_table_with_report_drain DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // scoreboard copy of the table and framing
   logic [7:0]  tab_kind [DEPTH];
   logic [7:0]  tab_rssi [DEPTH];
   logic [63:0] tab_word [DEPTH][3];
   logic [4:0]  tab_len  [DEPTH];
   int unsigned wr_ptr, rd_ptr, fill;
   logic        report_open;
   logic [7:0]  msg_id, msg_entries;
   logic [11:0] msg_bytes;
   logic [10:0] byte_limit;
   logic [7:0]  entry_limit;

   logic [239:0] expected_beats [$];
   int           error_count = 0;
   int           idle_cycles = 0;
   bit           long_hold;
   int           burst_left;

   // response field map: low bit, width, name
   int    fld_lo [12] = '{0, 2, 3, 11, 19, 83, 147, 211, 216, 224, 232, 233};
   int    fld_w  [12] = '{2, 1, 8, 8, 64, 64, 64, 5, 8, 8, 1, 1};
   string fld_name [12] = '{"status", "entry_valid", "kind", "strength",
      "word_low", "word_mid", "word_high", "length", "msg_number",
      "entries", "close", "report_end"};

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] byte_mask(int unsigned len, int k);
      int n;
      if (len <= 8 * k) return 64'd0;
      n = len - 8 * k;
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   function automatic logic [239:0] put_field(logic [239:0] v, int f, logic [63:0] x);
      logic [239:0] m;
      m = ((240'd1 << fld_w[f]) - 240'd1) << fld_lo[f];
      return (v & ~m) | ((240'(x) << fld_lo[f]) & m);
   endfunction

   function automatic logic [63:0] get_field(logic [239:0] v, int f);
      return 64'((v >> fld_lo[f]) & ((240'd1 << fld_w[f]) - 240'd1));
   endfunction

   function automatic void restart_framing();
      report_open = 1'b0;
      msg_id = 8'd1;
      msg_entries = 8'd0;
      msg_bytes = HEADER_BYTES;
   endfunction

   // dedup lookup and append for a store
   function automatic logic [1:0] sighting_store(logic [215:0] d);
      logic [7:0]  kind, rssi;
      logic [63:0] w [3];
      int unsigned len, slot;
      bit          same;
      kind = d[7:0];
      rssi = d[15:8];
      len = d[212:208];
      if (len > MAXLEN) len = MAXLEN;
      for (int k = 0; k < 3; k++) w[k] = d[16 + 64 * k +: 64] & byte_mask(len, k);
      for (int i = 0; i < fill; i++) begin
         slot = (rd_ptr + i) % DEPTH;
         same = tab_kind[slot] == kind;
         for (int k = 0; k < 3; k++)
            if ((tab_word[slot][k] & byte_mask(len, k)) != w[k]) same = 0;
         if (same) begin
            if ($signed(tab_rssi[slot]) < $signed(rssi)) tab_rssi[slot] = rssi;
            return ST_UPDATED;
         end
      end
      if (fill >= DEPTH) return ST_DROPPED;
      slot = wr_ptr;
      tab_kind[slot] = kind;
      tab_rssi[slot] = rssi;
      tab_len[slot] = 5'(len);
      for (int k = 0; k < 3; k++) tab_word[slot][k] = w[k];
      wr_ptr = (slot + 1) % DEPTH;
      fill++;
      return (fill >= DEPTH) ? ST_FULL : ST_ADDED;
   endfunction

   // drain one entry and advance the message framing
   function automatic logic [239:0] report_pop();
      logic [239:0] r;
      int unsigned slot;
      r = '0;
      if (fill == 0) begin
         r = put_field(r, 8, 64'(8'd0 - msg_id));
         r = put_field(r, 9, 64'(msg_entries));
         r = put_field(r, 10, 64'd1);
         r = put_field(r, 11, 64'd1);
         restart_framing();
         return r;
      end
      if (!report_open) begin
         restart_framing();
         report_open = 1'b1;
      end
      slot = rd_ptr;
      r = put_field(r, 1, 64'd1);
      r = put_field(r, 2, 64'(tab_kind[slot]));
      r = put_field(r, 3, 64'(8'(tab_rssi[slot] + RSSI_OFFSET)));
      for (int k = 0; k < 3; k++) r = put_field(r, 4 + k, tab_word[slot][k]);
      r = put_field(r, 7, 64'(tab_len[slot]));
      msg_entries = msg_entries + 8'd1;
      msg_bytes = msg_bytes + 12'(tab_len[slot]) + ENTRY_HDR_BYTES;
      rd_ptr = (slot + 1) % DEPTH;
      fill--;
      r = put_field(r, 9, 64'(msg_entries));
      if (fill == 0) begin
         r = put_field(r, 8, 64'(8'd0 - msg_id));
         r = put_field(r, 10, 64'd1);
         r = put_field(r, 11, 64'd1);
         restart_framing();
      end else if (msg_bytes >= 12'(byte_limit) || msg_entries >= entry_limit) begin
         r = put_field(r, 8, 64'(msg_id));
         r = put_field(r, 10, 64'd1);
         msg_id = msg_id + 8'd1;
         msg_entries = 8'd0;
         msg_bytes = HEADER_BYTES;
      end else begin
         r = put_field(r, 8, 64'(msg_id));
      end
      return r;
   endfunction

   function automatic logic [239:0] predict_response(logic [1:0] op, logic [215:0] d);
      logic [239:0] r;
      r = '0;
      case (op)
         OP_STORE: begin
            r = put_field(r, 0, 64'(sighting_store(d)));
         end
         OP_POP: begin
            r = report_pop();
         end
         OP_CLEAR: begin
            wr_ptr = 0;
            rd_ptr = 0;
            fill = 0;
            restart_framing();
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // offer one beat; keep tvalid up inside a burst, idle between bursts
   task automatic send_beat(logic [1:0] op, logic [215:0] d, bit typed = 0,
                            logic [239:0] typed_rsp = '0);
      logic [239:0] p;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = predict_response(op, d);
      expected_beats.push_back(typed ? typed_rsp : p);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [10:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BYTE_LIMIT) byte_limit = v;
      else entry_limit = v[7:0];
   endtask

   function automatic logic [215:0] pack_req(logic [7:0] kind, logic [7:0] rssi,
      logic [63:0] w0, logic [63:0] w1, logic [63:0] w2, logic [4:0] len);
      return {3'd0, len, w2, w1, w0, rssi, kind};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // small pool of beacon identities so repeats hit existing entries
   logic [7:0]  pool_kind [8];
   logic [63:0] pool_word [8][3];

   task automatic random_beat(int store_pct);
      int          sel, p;
      logic [1:0]  op;
      logic [4:0]  len;
      logic [63:0] w [3];
      logic [7:0]  kind;
      sel = $urandom_range(99);
      if (sel < store_pct) op = OP_STORE;
      else if (sel < 96) op = OP_POP;
      else if (sel < 98) op = OP_CLEAR;
      else op = 2'd3;
      p = $urandom_range(7);
      len = ($urandom_range(9) == 0) ? 5'($urandom_range(25, 31)) : 5'($urandom_range(0, 24));
      if ($urandom_range(2) == 0) begin
         kind = 8'($urandom);
         for (int k = 0; k < 3; k++) w[k] = rand64();
      end else begin
         kind = pool_kind[p];
         for (int k = 0; k < 3; k++)
            w[k] = pool_word[p][k] | (rand64() & ~byte_mask(len, k));
      end
      send_beat(op, pack_req(kind, 8'($urandom), w[0], w[1], w[2], len));
   endtask

   // response checker
   always @(posedge clock) begin
      logic [239:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $display("unexpected response beat %h at %0t", rsp_tdata, $realtime);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            for (int f = 0; f < 12; f++)
               if (get_field(rsp_tdata, f) != get_field(want, f))
                  report_mismatch(fld_name[f], get_field(rsp_tdata, f), get_field(want, f));
            if (rsp_tdata[239:234] != 6'd0)
               report_mismatch("fill", 64'(rsp_tdata[239:234]), 64'd0);
         end
      end
   end

   // receiver back-pressure, with one long hold-off on request
   initial begin
      int hold_count;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            hold_count++;
            if (hold_count >= 600) long_hold = 0;
         end else begin
            case ($urandom_range(3))
               0: rsp_tready <= 1'b0;
               default: rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // directed rows
   typedef struct {
      logic [1:0]   op;
      logic [215:0] data;
      bit           typed;
      logic [239:0] rsp;
   } row_type;

   row_type rows [$];

   function automatic void add_row(logic [1:0] op, logic [215:0] d, bit typed,
                                   logic [239:0] r);
      row_type x;
      x.op = op;
      x.data = d;
      x.typed = typed;
      x.rsp = r;
      rows.push_back(x);
   endfunction

   initial begin
      logic [239:0] empty_close, zero_rsp;
      logic [63:0]  ones;
      int           n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_STORE;
      csr_we = 1'b0;
      csr_index = CSR_BYTE_LIMIT;
      csr_wdata = '0;
      long_hold = 0;
      burst_left = 1;
      wr_ptr = 0;
      rd_ptr = 0;
      fill = 0;
      restart_framing();
      byte_limit = BYTE_LIMIT_RESET;
      entry_limit = ENTRY_LIMIT_RESET;
      for (int p = 0; p < 8; p++) begin
         pool_kind[p] = 8'($urandom);
         for (int k = 0; k < 3; k++) pool_word[p][k] = rand64();
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ones = '1;
      zero_rsp = '0;
      empty_close = put_field(put_field(put_field('0, 8, 64'hFF), 10, 64'd1), 11, 64'd1);
      // pop on empty table, unknown operation, extremes of strength and length
      add_row(OP_POP, '0, 1, empty_close);
      add_row(2'd3, '1, 1, zero_rsp);
      add_row(OP_STORE, pack_req(8'h00, 8'h80, ones, ones, ones, 5'd24), 1, zero_rsp);
      add_row(OP_STORE, pack_req(8'h00, 8'h7F, ones, ones, ones, 5'd24), 1,
              put_field('0, 0, 64'(ST_UPDATED)));
      add_row(OP_STORE, pack_req(8'hFF, 8'h00, '0, '0, '0, 5'd0), 1, zero_rsp);
      add_row(OP_STORE, pack_req(8'hFF, 8'h9C, ones, 64'h5, 64'h7, 5'd0), 0, '0);
      add_row(OP_STORE, pack_req(8'h07, 8'hD0, rand64(), rand64(), rand64(), 5'd31), 0, '0);
      add_row(OP_STORE, pack_req(8'h07, 8'hC0, 64'h0123456789ABCDEF, ones, ones, 5'd8),
              0, '0);
      add_row(OP_STORE, pack_req(8'h07, 8'hE0, 64'h0123456789ABCDEF, '0, '0, 5'd8), 0, '0);
      add_row(OP_STORE, pack_req(8'h00, 8'h10, ones, ones, ones, 5'd23), 0, '0);
      for (int i = 0; i < 5; i++) add_row(OP_POP, '0, 0, '0);
      add_row(OP_POP, '0, 1, empty_close);
      add_row(OP_STORE, pack_req(8'h33, 8'h01, rand64(), '0, '0, 5'd3), 0, '0);
      add_row(OP_STORE, pack_req(8'h34, 8'hFE, rand64(), '0, '0, 5'd16), 0, '0);
      add_row(OP_CLEAR, '1, 1, zero_rsp);
      add_row(OP_POP, '0, 1, empty_close);
      add_row(OP_STORE, pack_req(8'h35, 8'h64, rand64(), rand64(), '0, 5'd12), 0, '0);
      add_row(OP_POP, '0, 0, '0);
      foreach (rows[i]) send_beat(rows[i].op, rows[i].data, rows[i].typed, rows[i].rsp);

      // tight limits: every entry closes a message
      write_csr(CSR_BYTE_LIMIT, 11'd16);
      write_csr(CSR_ENTRY_LIMIT, 11'd1);
      for (int i = 0; i < 150; i++) random_beat(60);
      long_hold = 1;
      for (int i = 0; i < 6; i++) random_beat(60);
      wait_drained();

      // widest limits, then fill the table until sightings are dropped
      write_csr(CSR_BYTE_LIMIT, 11'd2047);
      write_csr(CSR_ENTRY_LIMIT, 11'd255);
      send_beat(OP_CLEAR, '0);
      for (int i = 0; i < 262; i++)
         send_beat(OP_STORE, pack_req(8'($urandom), 8'($urandom), rand64(), rand64(),
                   rand64(), 5'd24));
      for (int i = 0; i < 8; i++) random_beat(90);
      for (int i = 0; i < 270; i++) send_beat(OP_POP, '0);
      wait_drained();

      // entry limit zero and a short byte limit
      write_csr(CSR_ENTRY_LIMIT, 11'd0);
      write_csr(CSR_BYTE_LIMIT, 11'd40);
      for (int i = 0; i < 150; i++) random_beat(65);

      // random limits over several phases
      n = 0;
      while (n < 5) begin
         write_csr(CSR_BYTE_LIMIT, 11'($urandom_range(16, 2047)));
         write_csr(CSR_ENTRY_LIMIT, 11'($urandom_range(1, 255)));
         for (int i = 0; i < 80; i++) random_beat(70);
         n++;
      end
      wait_drained();
      write_csr(CSR_BYTE_LIMIT, 11'd1024);
      for (int i = 0; i < 60; i++) random_beat(55);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* beacon_dedup_table_with_report_drain.f */
design/bdt_pkg.sv
design/beacon_dedup_table_with_report_drain.sv
tb/sv/beacon_dedup_table_with_report_drain_tb.sv
